>>> rtl/core/mctm_pkg.sv
package mctm_pkg;

	localparam int CHANNELS = 8;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int OP_W     = 3;
	localparam int CH_W     = 4;
	localparam int TMO_W    = 16;
	localparam int LOST_W   = 8;

	localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
	localparam logic [OP_W-1:0] OP_REGISTER = 3'd1;
	localparam logic [OP_W-1:0] OP_FEED     = 3'd2;
	localparam logic [OP_W-1:0] OP_ARM      = 3'd3;
	localparam logic [OP_W-1:0] OP_DISARM   = 3'd4;

	typedef struct packed {
		logic             enabled;
		logic             fed;
		logic             lapsed;
		logic             pending;
		logic [TMO_W-1:0] elapsed;
		logic [TMO_W-1:0] limit;
	} chan_t;

endpackage

>>> rtl/core/mctm_tick_unit.sv
module mctm_tick_unit (
	input  mctm_pkg::chan_t cur,
	output mctm_pkg::chan_t nxt,
	output logic            fire
);
	import mctm_pkg::*;

	logic [TMO_W-1:0] el_inc;

	always_comb begin
		nxt    = cur;
		fire   = 1'b0;
		el_inc = (cur.elapsed < cur.limit) ? cur.elapsed + TMO_W'(1) : cur.elapsed;
		if (cur.enabled) begin
			if (cur.pending) begin
				nxt.pending = 1'b0;
				nxt.elapsed = '0;
				nxt.fed     = 1'b1;
				nxt.lapsed  = 1'b0;
			end else begin
				nxt.elapsed = el_inc;
				if (el_inc >= cur.limit && !cur.lapsed) begin
					nxt.lapsed = 1'b1;
					fire       = 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/core/multi_channel_timeout_monitor.sv
// Channel   Direction  Fields                                   Handshake
// command   in         operation[3] channel[4] timeout[16]      start, busy
// result    out        accepted healthy expired lost_mask[8]    done (one-cycle strobe)
//
// A tick walks the channels through one shared update unit, one channel a cycle.
// The scan then passes through DONE back to idle; other words go through EXEC and DONE.
// busy stays high until the result strobe; a new word may start in the strobe cycle.
// arst_n clears every channel (limit zero = unregistered). No stall on results.
module multi_channel_timeout_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [mctm_pkg::OP_W-1:0]   operation,
	input  logic [mctm_pkg::CH_W-1:0]   channel,
	input  logic [mctm_pkg::TMO_W-1:0]  timeout,
	output logic                        done,
	output logic                        accepted,
	output logic                        healthy,
	output logic                        expired,
	output logic [mctm_pkg::LOST_W-1:0] lost_mask
);
	import mctm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [OP_W-1:0]   op_q;
	logic [CH_W-1:0]   ch_q;
	logic [TMO_W-1:0]  tmo_q;
	logic              valid_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [LOST_W-1:0] lost_q;
	logic              acc_q;
	logic              done_q;
	logic              healthy_q;
	logic              expired_q;
	chan_t             chan_q [CHANNELS];

	logic              in_valid;
	logic [IDX_W-1:0]  ch_idx;
	logic [IDX_W-1:0]  rd_idx;
	chan_t             rd_ent;
	chan_t             tick_ent;
	logic              tick_fire;
	chan_t             op_ent;
	logic              op_acc;

	assign in_valid = {1'b0, channel} < (CH_W + 1)'(CHANNELS);
	assign ch_idx   = valid_q ? ch_q[IDX_W-1:0] : '0;
	assign rd_idx   = (state_q == ST_SCAN) ? scan_idx_q : ch_idx;
	assign rd_ent   = chan_q[rd_idx];
	assign busy     = (state_q != ST_IDLE);

	mctm_tick_unit u_tick (
		.cur  (rd_ent),
		.nxt  (tick_ent),
		.fire (tick_fire)
	);

	always_comb begin
		op_ent = rd_ent;
		op_acc = 1'b0;
		unique case (op_q)
			OP_REGISTER: begin
				if (tmo_q != '0) begin
					op_ent.limit   = tmo_q;
					op_ent.elapsed = '0;
					op_ent.fed     = 1'b0;
					op_ent.lapsed  = 1'b0;
					op_ent.pending = 1'b0;
					op_ent.enabled = 1'b1;
					op_acc         = 1'b1;
				end
			end
			OP_FEED: begin
				if (rd_ent.enabled) begin
					op_ent.pending = 1'b1;
					op_ent.elapsed = '0;
					op_ent.fed     = 1'b1;
					op_ent.lapsed  = 1'b0;
				end
				op_acc = 1'b1;
			end
			OP_ARM: begin
				if (rd_ent.limit != '0) begin
					op_ent.pending = 1'b0;
					op_ent.elapsed = '0;
					op_ent.fed     = 1'b1;
					op_ent.lapsed  = 1'b0;
					op_ent.enabled = 1'b1;
					op_acc         = 1'b1;
				end
			end
			OP_DISARM: begin
				op_ent.enabled = 1'b0;
				op_ent.elapsed = '0;
				op_ent.fed     = 1'b0;
				op_ent.lapsed  = 1'b0;
				op_acc         = 1'b1;
			end
			default: begin
				op_acc = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			done_q     <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				chan_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						scan_idx_q <= '0;
						state_q    <= (operation == OP_TICK) ? ST_SCAN : ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (valid_q) begin
						chan_q[ch_idx] <= op_ent;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					chan_q[scan_idx_q] <= tick_ent;
					if (scan_idx_q == IDX_W'(CHANNELS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// word and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q    <= operation;
			ch_q    <= channel;
			tmo_q   <= timeout;
			valid_q <= in_valid;
			lost_q  <= '0;
			acc_q   <= (operation == OP_TICK) && in_valid;
		end
		if (state_q == ST_EXEC) begin
			acc_q <= valid_q && op_acc;
		end
		if (state_q == ST_SCAN && tick_fire) begin
			lost_q <= lost_q | (LOST_W'(1) << scan_idx_q);
		end
		if (state_q == ST_DONE) begin
			healthy_q <= valid_q && rd_ent.enabled && rd_ent.fed && !rd_ent.lapsed;
			expired_q <= !valid_q || !rd_ent.enabled || rd_ent.lapsed;
		end
	end

	assign done      = done_q;
	assign accepted  = acc_q;
	assign healthy   = healthy_q;
	assign expired   = expired_q;
	assign lost_mask = lost_q;

endmodule

>>> tb/tb_multi_channel_timeout_monitor.sv
`timescale 1ns / 100ps

module tb_multi_channel_timeout_monitor;

	import mctm_pkg::*;

	localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic              accepted;
		logic              healthy;
		logic              expired;
		logic [LOST_W-1:0] lost_mask;
	} status_t;

	class heartbeat_board;
		chan_t       chans[CHANNELS];
		status_t     status_q[$];
		int unsigned errors;
		int unsigned words;
		int unsigned ticks;
		int unsigned expiries;
		int unsigned checked;

		function new();
			foreach (chans[k])
				chans[k] = '0;
			errors   = 0;
			words    = 0;
			ticks    = 0;
			expiries = 0;
			checked  = 0;
		endfunction

		function status_t predict_status(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
				logic [TMO_W-1:0] tmo);
			status_t st;
			logic    valid;
			int      c;
			st    = '0;
			valid = (ch < CHANNELS);
			c     = valid ? int'(ch) : 0;
			if (op == OP_TICK) begin
				for (int k = 0; k < CHANNELS; k++) begin
					if (!chans[k].enabled)
						continue;
					if (chans[k].pending) begin
						chans[k].pending = 1'b0;
						chans[k].elapsed = '0;
						chans[k].fed     = 1'b1;
						chans[k].lapsed  = 1'b0;
						continue;
					end
					if (chans[k].elapsed < chans[k].limit)
						chans[k].elapsed = chans[k].elapsed + 1'b1;
					if (chans[k].elapsed >= chans[k].limit && !chans[k].lapsed) begin
						chans[k].lapsed = 1'b1;
						if (k < LOST_W)
							st.lost_mask[k] = 1'b1;
					end
				end
				st.accepted = valid;
			end else if (valid) begin
				case (op)
					OP_REGISTER: begin
						if (tmo != '0) begin
							chans[c].limit   = tmo;
							chans[c].elapsed = '0;
							chans[c].fed     = 1'b0;
							chans[c].lapsed  = 1'b0;
							chans[c].pending = 1'b0;
							chans[c].enabled = 1'b1;
							st.accepted      = 1'b1;
						end
					end
					OP_FEED: begin
						if (chans[c].enabled) begin
							chans[c].pending = 1'b1;
							chans[c].elapsed = '0;
							chans[c].fed     = 1'b1;
							chans[c].lapsed  = 1'b0;
						end
						st.accepted = 1'b1;
					end
					OP_ARM: begin
						if (chans[c].limit != '0) begin
							chans[c].pending = 1'b0;
							chans[c].elapsed = '0;
							chans[c].fed     = 1'b1;
							chans[c].lapsed  = 1'b0;
							chans[c].enabled = 1'b1;
							st.accepted      = 1'b1;
						end
					end
					OP_DISARM: begin
						chans[c].enabled = 1'b0;
						chans[c].elapsed = '0;
						chans[c].fed     = 1'b0;
						chans[c].lapsed  = 1'b0;
						st.accepted      = 1'b1;
					end
					default: ;
				endcase
			end
			if (valid) begin
				st.healthy = chans[c].enabled && chans[c].fed && !chans[c].lapsed;
				st.expired = !chans[c].enabled || chans[c].lapsed;
			end else begin
				st.healthy = 1'b0;
				st.expired = 1'b1;
			end
			return st;
		endfunction

		function void note_word(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
				logic [TMO_W-1:0] tmo);
			status_t st;
			st = predict_status(op, ch, tmo);
			words++;
			if (op == OP_TICK)
				ticks++;
			expiries += $countones(st.lost_mask);
			status_q.push_back(st);
		endfunction

		function void check_status(status_t got);
			status_t want;
			if (status_q.size() == 0) begin
				$error("result with no word outstanding: %p", got);
				errors++;
				return;
			end
			want = status_q.pop_front();
			checked++;
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
				errors++;
			end
			if (got.healthy !== want.healthy) begin
				$error("healthy: expected %0b, got %0b", want.healthy, got.healthy);
				errors++;
			end
			if (got.expired !== want.expired) begin
				$error("expired: expected %0b, got %0b", want.expired, got.expired);
				errors++;
			end
			if (got.lost_mask !== want.lost_mask) begin
				$error("lost_mask: expected %02h, got %02h", want.lost_mask, got.lost_mask);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [OP_W-1:0]     operation;
	logic [CH_W-1:0]     channel;
	logic [TMO_W-1:0]    timeout;
	logic                done;
	logic                accepted;
	logic                healthy;
	logic                expired;
	logic [LOST_W-1:0]   lost_mask;

	heartbeat_board board;
	int unsigned    cycle_count;
	int             burst_left;

	multi_channel_timeout_monitor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.channel   (channel),
		.timeout   (timeout),
		.done      (done),
		.accepted  (accepted),
		.healthy   (healthy),
		.expired   (expired),
		.lost_mask (lost_mask)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles", cycle_count);
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_status({accepted, healthy, expired, lost_mask});
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
			input logic [TMO_W-1:0] tmo);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		start     <= 1'b1;
		operation <= op;
		channel   <= ch;
		timeout   <= tmo;
		do
			@(posedge clk);
		while (busy);
		board.note_word(op, ch, tmo);
	endtask

	function automatic logic [CH_W-1:0] pick_channel();
		if ($urandom_range(0, 9) == 0)
			return CH_W'($urandom_range(CHANNELS, (1 << CH_W) - 1));
		return CH_W'($urandom_range(0, CHANNELS - 1));
	endfunction

	function automatic logic [TMO_W-1:0] pick_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return TMO_W'($urandom_range(1, 4));
		if (r < 70)
			return TMO_W'($urandom_range(5, 40));
		if (r < 80)
			return '0;
		if (r < 88)
			return '1;
		return TMO_W'($urandom());
	endfunction

	task automatic send_random_word();
		int               r;
		logic [OP_W-1:0]  op;
		logic [TMO_W-1:0] tmo;
		r   = $urandom_range(0, 99);
		tmo = TMO_W'($urandom());
		if (r < 40)
			op = OP_TICK;
		else if (r < 54) begin
			op  = OP_REGISTER;
			tmo = pick_limit();
		end else if (r < 74)
			op = OP_FEED;
		else if (r < 86)
			op = OP_ARM;
		else if (r < 96)
			op = OP_DISARM;
		else
			op = OP_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
		send_word(op, pick_channel(), tmo);
	endtask

	initial begin
		board      = new();
		burst_left = 0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		operation <= OP_TICK;
		channel   <= '0;
		timeout   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		send_word(OP_TICK, 4'd0, 16'd0);
		send_word(OP_ARM, 4'd0, 16'd5);
		send_word(OP_FEED, 4'd1, 16'd0);
		send_word(OP_REGISTER, 4'd0, 16'd0);
		send_word(OP_REGISTER, 4'd0, 16'd1);
		send_word(OP_TICK, 4'd0, 16'hFFFF);
		send_word(OP_TICK, 4'd0, 16'd0);
		send_word(OP_FEED, 4'd0, 16'd0);
		send_word(OP_TICK, 4'd0, 16'd0);
		send_word(OP_TICK, 4'd0, 16'd0);
		send_word(OP_REGISTER, CH_W'(CHANNELS - 1), 16'hFFFF);
		send_word(OP_ARM, CH_W'(CHANNELS - 1), 16'd0);
		send_word(OP_FEED, CH_W'(CHANNELS - 1), 16'd0);
		send_word(OP_DISARM, CH_W'(CHANNELS - 1), 16'd0);
		// pending mark survives disarm; arm drops it
		send_word(OP_FEED, CH_W'(CHANNELS - 1), 16'd0);
		send_word(OP_ARM, CH_W'(CHANNELS - 1), 16'd0);
		send_word(OP_REGISTER, 4'd15, 16'd3);
		send_word(OP_TICK, 4'd15, 16'd0);
		send_word(OP_DISARM, CH_W'(CHANNELS), 16'd0);
		send_word(OP_UNKNOWN_FIRST, 4'd0, 16'hAAAA);
		send_word(OP_UNKNOWN_LAST, 4'd3, 16'h5555);
		send_word(OP_REGISTER, 4'd3, 16'd2);
		send_word(OP_TICK, 4'd3, 16'd0);
		send_word(OP_TICK, 4'd3, 16'd0);
		send_word(OP_TICK, 4'd3, 16'd0);

		repeat (850)
			send_random_word();
		start <= 1'b0;

		while (board.status_q.size() != 0)
			@(posedge clk);
		repeat (CHANNELS + 6) @(posedge clk);

		$display("Sent %0d command words (%0d ticks); %0d channel expiries seen in lost_mask.",
			board.words, board.ticks, board.expiries);
		$display("Checked %0d results, %0d field mismatches.", board.checked, board.errors);
		if (board.errors == 0 && board.status_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
